// ===== rtl/rpdc_pkg.sv =====
// shared types and constants for the radar point doppler compensation pipeline
// no dependencies; imported by every rtl module of the block
package rpdc_pkg;

    localparam int COORD_W   = 24;
    localparam int DMAG_W    = 25;
    localparam int SQ_W      = 50;
    localparam int RAD_W     = 64;
    localparam int ROOT_W    = 32;
    localparam int SQRT_LAT  = 32;
    localparam int QUO_W     = 25;
    localparam int DIV_LAT   = QUO_W;
    localparam int DVD_W     = 56;
    localparam int VAGE_W    = 36;
    localparam int PROD_W    = 61;
    localparam int UHI_W     = 12;
    localparam int ULO_W     = 13;
    localparam int MAG_W     = 26;
    localparam int AGE_W     = 20;
    localparam int TOFF_W    = 21;
    localparam int IDX_W     = 8;
    localparam int IN_DATA_W  = 176;
    localparam int OUT_DATA_W = 128;

    localparam logic [QUO_W-1:0] UNIT_ONE = QUO_W'(1) << 24;

    typedef enum logic [IDX_W-1:0] {
        REG_INTENSITY_MIN    = 8'd0,
        REG_PROJECT_TO_PLANE = 8'd1,
        REG_DOPPLER_ENABLE   = 8'd2,
        REG_MIN_PLANAR_RANGE = 8'd3
    } reg_idx_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic [15:0]               intensity;
        logic signed [15:0]        radial_velocity;
        logic                      velocity_valid;
        logic [AGE_W-1:0]          frame_age;
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
    } point_t;

    typedef struct packed {
        logic                      keep;
        logic                      project;
        logic                      want;
        logic [15:0]               min_range;
    } ctrl_t;

    typedef struct packed {
        logic                      valid;
        logic                      keep;
        logic                      shift;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [15:0]               intensity;
        logic signed [15:0]        velocity;
        logic [AGE_W-1:0]          age;
        logic                      vneg;
        logic                      dxneg;
        logic                      dyneg;
        logic [DMAG_W-1:0]         dxmag;
        logic [DMAG_W-1:0]         dymag;
        logic [VAGE_W-1:0]         vage;
    } meta_t;

endpackage

// ===== rtl/radar_point_doppler_compensate.sv =====
// Radar point Doppler compensation, one point per clock cycle when the output side
// keeps up. The pipeline has three front stages (offsets, squares, range test),
// 32 square-root stages, 25 divider stages and three back stages (products, rounding,
// saturation, output register). The whole pipeline advances together; it holds
// when the output register is full and not taken. Configuration is always ready.
// depends on rpdc_pkg, rpdc_front, rpdc_isqrt, rpdc_div, rpdc_back
module radar_point_doppler_compensate (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // point_x, point_y, point_z, intensity, radial_velocity, frame_age,
    // origin x, origin y, zero fill
    input  logic [rpdc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // velocity_valid
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_x, out_y, out_z, out_intensity, out_velocity, negated age, zero fill
    output logic [rpdc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // keep, compensated
    output logic [1:0]  m_axis_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [rpdc_pkg::IDX_W-1:0] cfg_index,
    input  logic [15:0] cfg_data
);
    import rpdc_pkg::*;

    logic        en;
    logic [15:0] intensity_min_reg;
    logic        project_reg;
    logic        doppler_reg;
    logic [15:0] min_range_reg;
    point_t      pt;
    ctrl_t       ctrl;
    meta_t       front_meta;
    logic [SQ_W-1:0] sq_sum;
    meta_t       sq_q_reg  [SQRT_LAT];
    meta_t       div_q_reg [DIV_LAT];
    meta_t       sq_out;
    logic [ROOT_W-1:0] r7;
    logic [QUO_W-1:0]  qx, qy;
    logic        keep, compensated;
    logic signed [COORD_W-1:0] out_x, out_y, out_z;
    logic [15:0] out_intensity;
    logic signed [15:0] out_velocity;
    logic signed [TOFF_W-1:0] out_toff;

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            intensity_min_reg <= 16'd240;
            project_reg       <= 1'b1;
            doppler_reg       <= 1'b1;
            min_range_reg     <= 16'd4;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_INTENSITY_MIN:    intensity_min_reg <= cfg_data;
                REG_PROJECT_TO_PLANE: project_reg       <= cfg_data[0];
                REG_DOPPLER_ENABLE:   doppler_reg       <= cfg_data[0];
                REG_MIN_PLANAR_RANGE: min_range_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        pt.point_x         = s_axis_tdata[23:0];
        pt.point_y         = s_axis_tdata[47:24];
        pt.point_z         = s_axis_tdata[71:48];
        pt.intensity       = s_axis_tdata[87:72];
        pt.radial_velocity = s_axis_tdata[103:88];
        pt.frame_age       = s_axis_tdata[123:104];
        pt.origin_x        = s_axis_tdata[147:124];
        pt.origin_y        = s_axis_tdata[171:148];
        pt.velocity_valid  = s_axis_tuser;
        ctrl.keep      = pt.intensity >= intensity_min_reg;
        ctrl.project   = project_reg;
        ctrl.want      = doppler_reg && (pt.frame_age != '0) && pt.velocity_valid;
        ctrl.min_range = min_range_reg;
    end

    rpdc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_axis_tvalid),
        .in_point (pt),
        .ctrl     (ctrl),
        .meta     (front_meta),
        .sq_sum   (sq_sum)
    );

    rpdc_isqrt u_isqrt (
        .clk      (clk),
        .en       (en),
        .radicand ({sq_sum, 14'd0}),
        .root     (r7)
    );

    // item side data rides alongside the root and divider stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SQRT_LAT; i++)
                sq_q_reg[i].valid <= 1'b0;
            for (int i = 0; i < DIV_LAT; i++)
                div_q_reg[i].valid <= 1'b0;
        end
        else if (en)
        begin
            sq_q_reg[0] <= front_meta;
            for (int i = 1; i < SQRT_LAT; i++)
                sq_q_reg[i] <= sq_q_reg[i-1];
            div_q_reg[0] <= sq_q_reg[SQRT_LAT-1];
            for (int i = 1; i < DIV_LAT; i++)
                div_q_reg[i] <= div_q_reg[i-1];
        end
    end

    assign sq_out = sq_q_reg[SQRT_LAT-1];

    rpdc_div u_div_x (
        .clk  (clk),
        .en   (en),
        .dmag (sq_out.dxmag),
        .r7   (r7),
        .quo  (qx)
    );

    rpdc_div u_div_y (
        .clk  (clk),
        .en   (en),
        .dmag (sq_out.dymag),
        .r7   (r7),
        .quo  (qy)
    );

    rpdc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .meta          (div_q_reg[DIV_LAT-1]),
        .qx            (qx),
        .qy            (qy),
        .out_valid     (m_axis_tvalid),
        .keep          (keep),
        .compensated   (compensated),
        .out_x         (out_x),
        .out_y         (out_y),
        .out_z         (out_z),
        .out_intensity (out_intensity),
        .out_velocity  (out_velocity),
        .out_toff      (out_toff)
    );

    assign m_axis_tdata = {3'd0, out_toff, out_velocity, out_intensity,
                           out_z, out_y, out_x};
    assign m_axis_tuser = {compensated, keep};

    a_comp_needs_keep: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && compensated |-> keep)
        else $error("shift applied to a dropped point");

    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !keep |-> m_axis_tdata == '0)
        else $error("dropped point carries data");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output changed");

endmodule

// ===== rtl/rpdc_front.sv =====
// front end: carries the threshold result, offsets from the radar origin, squares and range test
// depends on rpdc_pkg; three register stages
module rpdc_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  rpdc_pkg::point_t      in_point,
    input  rpdc_pkg::ctrl_t       ctrl,
    output rpdc_pkg::meta_t       meta,
    output logic [rpdc_pkg::SQ_W-1:0] sq_sum
);
    import rpdc_pkg::*;

    logic              v1_reg, v2_reg, v3_reg;
    point_t            p1_reg;
    ctrl_t             c1_reg;
    logic signed [DMAG_W-1:0] dx1_reg, dy1_reg;
    meta_t             m2_reg, m3_reg;
    meta_t             m3_next;
    logic [SQ_W-2:0]   dx2_reg, dy2_reg;
    logic [31:0]       mpr2_reg;
    logic [SQ_W-1:0]   s3_reg;
    logic [SQ_W-1:0]   s_next;
    logic [15:0]       vmag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // stage 1: capture, offsets
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg  <= in_point;
            c1_reg  <= ctrl;
            dx1_reg <= DMAG_W'(in_point.point_x) - DMAG_W'(in_point.origin_x);
            dy1_reg <= DMAG_W'(in_point.point_y) - DMAG_W'(in_point.origin_y);
        end
    end

    assign vmag = p1_reg.radial_velocity[15] ? 16'(-p1_reg.radial_velocity)
                                             : 16'(p1_reg.radial_velocity);

    // stage 2: squares
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m2_reg.valid     <= v1_reg;
            m2_reg.keep      <= c1_reg.keep;
            m2_reg.shift     <= c1_reg.want;
            m2_reg.x         <= p1_reg.point_x;
            m2_reg.y         <= p1_reg.point_y;
            m2_reg.z         <= c1_reg.project ? '0 : p1_reg.point_z;
            m2_reg.intensity <= p1_reg.intensity;
            m2_reg.velocity  <= p1_reg.radial_velocity;
            m2_reg.age       <= p1_reg.frame_age;
            m2_reg.vneg      <= p1_reg.radial_velocity[15];
            m2_reg.dxneg     <= dx1_reg[DMAG_W-1];
            m2_reg.dyneg     <= dy1_reg[DMAG_W-1];
            m2_reg.dxmag     <= dx1_reg[DMAG_W-1] ? DMAG_W'(-dx1_reg) : DMAG_W'(dx1_reg);
            m2_reg.dymag     <= dy1_reg[DMAG_W-1] ? DMAG_W'(-dy1_reg) : DMAG_W'(dy1_reg);
            m2_reg.vage      <= VAGE_W'(vmag) * VAGE_W'(p1_reg.frame_age);
            dx2_reg <= (SQ_W-1)'($signed(dx1_reg) * $signed(dx1_reg));
            dy2_reg <= (SQ_W-1)'($signed(dy1_reg) * $signed(dy1_reg));
            mpr2_reg <= 32'(c1_reg.min_range) * 32'(c1_reg.min_range);
        end
    end

    assign s_next = SQ_W'(dx2_reg) + SQ_W'(dy2_reg);

    always_comb
    begin
        m3_next       = m2_reg;
        m3_next.shift = m2_reg.shift && (s_next > SQ_W'(mpr2_reg));
    end

    // stage 3: sum and range test
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m3_reg <= m3_next;
            s3_reg <= s_next;
        end
    end

    always_comb
    begin
        meta       = m3_reg;
        meta.valid = v3_reg;
    end
    assign sq_sum = s3_reg;

endmodule

// ===== rtl/rpdc_isqrt.sv =====
// pipelined integer square root, one root bit per stage
// depends on rpdc_pkg
module rpdc_isqrt (
    input  logic                          clk,
    input  logic                          en,
    input  logic [rpdc_pkg::RAD_W-1:0]    radicand,
    output logic [rpdc_pkg::ROOT_W-1:0]   root
);
    import rpdc_pkg::*;

    logic [RAD_W-1:0] n_reg   [SQRT_LAT];
    logic [RAD_W-1:0] res_reg [SQRT_LAT];

    for (genvar i = 0; i < SQRT_LAT; i++)
    begin : g_stage
        localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (RAD_W - 2 - 2 * i);
        logic [RAD_W-1:0] n_prev, r_prev, trial;
        if (i == 0)
        begin : g_first
            assign n_prev = radicand;
            assign r_prev = '0;
        end
        else
        begin : g_rest
            assign n_prev = n_reg[i-1];
            assign r_prev = res_reg[i-1];
        end
        assign trial = r_prev + BIT;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (n_prev >= trial)
                begin
                    n_reg[i]   <= n_prev - trial;
                    res_reg[i] <= (r_prev >> 1) + BIT;
                end
                else
                begin
                    n_reg[i]   <= n_prev;
                    res_reg[i] <= r_prev >> 1;
                end
            end
        end
    end

    assign root = res_reg[SQRT_LAT-1][ROOT_W-1:0];

endmodule

// ===== rtl/rpdc_div.sv =====
// pipelined restoring divider for the unit vector component, rounded half up
// depends on rpdc_pkg; one quotient bit per stage
module rpdc_div (
    input  logic                          clk,
    input  logic                          en,
    input  logic [rpdc_pkg::DMAG_W-1:0]   dmag,
    input  logic [rpdc_pkg::ROOT_W-1:0]   r7,
    output logic [rpdc_pkg::QUO_W-1:0]    quo
);
    import rpdc_pkg::*;

    logic [DVD_W-1:0]  rem_reg [DIV_LAT];
    logic [ROOT_W-1:0] d_reg   [DIV_LAT];
    logic [QUO_W-1:0]  q_reg   [DIV_LAT];
    logic [DVD_W-1:0]  dividend;

    assign dividend = (DVD_W'(dmag) << 31) + DVD_W'(r7 >> 1);

    for (genvar i = 0; i < DIV_LAT; i++)
    begin : g_stage
        localparam int POS = QUO_W - 1 - i;
        logic [DVD_W-1:0]  rem_prev, dsh;
        logic [ROOT_W-1:0] d_prev;
        logic [QUO_W-1:0]  q_prev;
        if (i == 0)
        begin : g_first
            assign rem_prev = dividend;
            assign d_prev   = r7;
            assign q_prev   = '0;
        end
        else
        begin : g_rest
            assign rem_prev = rem_reg[i-1];
            assign d_prev   = d_reg[i-1];
            assign q_prev   = q_reg[i-1];
        end
        assign dsh = DVD_W'(d_prev) << POS;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_reg[i] <= d_prev;
                if (rem_prev >= dsh)
                begin
                    rem_reg[i] <= rem_prev - dsh;
                    q_reg[i]   <= q_prev | (QUO_W'(1) << POS);
                end
                else
                begin
                    rem_reg[i] <= rem_prev;
                    q_reg[i]   <= q_prev;
                end
            end
        end
    end

    assign quo = q_reg[DIV_LAT-1];

endmodule

// ===== rtl/rpdc_back.sv =====
// back end: shift magnitude products, rounding, sign, add and saturate
// depends on rpdc_pkg; three register stages, the last is the output register
module rpdc_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  rpdc_pkg::meta_t             meta,
    input  logic [rpdc_pkg::QUO_W-1:0]  qx,
    input  logic [rpdc_pkg::QUO_W-1:0]  qy,
    output logic                        out_valid,
    output logic                        keep,
    output logic                        compensated,
    output logic signed [rpdc_pkg::COORD_W-1:0] out_x,
    output logic signed [rpdc_pkg::COORD_W-1:0] out_y,
    output logic signed [rpdc_pkg::COORD_W-1:0] out_z,
    output logic [15:0]                 out_intensity,
    output logic signed [15:0]          out_velocity,
    output logic signed [rpdc_pkg::TOFF_W-1:0] out_toff
);
    import rpdc_pkg::*;

    localparam logic signed [COORD_W+3:0] CMAX = (COORD_W+4)'(8388607);
    localparam logic signed [COORD_W+3:0] CMIN = -(COORD_W+4)'(8388608);

    meta_t m1_reg, m2_reg;
    logic  v1_reg, v2_reg, v3_reg;
    logic [QUO_W-1:0] ux, uy;
    logic [VAGE_W+ULO_W-1:0] pax_reg, pay_reg;
    logic [VAGE_W+UHI_W-1:0] pbx_reg, pby_reg;
    logic [PROD_W-1:0] px_reg, py_reg;
    logic [MAG_W-1:0] magx, magy;
    logic signed [COORD_W+3:0] sumx, sumy;
    logic k3_reg, c3_reg;
    logic signed [COORD_W-1:0] x3_reg, y3_reg, z3_reg;
    logic [15:0] i3_reg;
    logic signed [15:0] vel3_reg;
    logic signed [TOFF_W-1:0] t3_reg;

    assign ux = (qx > UNIT_ONE) ? UNIT_ONE : qx;
    assign uy = (qy > UNIT_ONE) ? UNIT_ONE : qy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= meta.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // split products keep each multiplier near 36 by 13
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_reg  <= meta;
            pax_reg <= (VAGE_W+ULO_W)'(meta.vage) * (VAGE_W+ULO_W)'(ux[ULO_W-1:0]);
            pbx_reg <= (VAGE_W+UHI_W)'(meta.vage) * (VAGE_W+UHI_W)'(ux[QUO_W-1:ULO_W]);
            pay_reg <= (VAGE_W+ULO_W)'(meta.vage) * (VAGE_W+ULO_W)'(uy[ULO_W-1:0]);
            pby_reg <= (VAGE_W+UHI_W)'(meta.vage) * (VAGE_W+UHI_W)'(uy[QUO_W-1:ULO_W]);
            m2_reg  <= m1_reg;
            px_reg  <= PROD_W'(pax_reg) + (PROD_W'(pbx_reg) << ULO_W);
            py_reg  <= PROD_W'(pay_reg) + (PROD_W'(pby_reg) << ULO_W);
        end
    end

    // round half away from zero on the magnitude
    assign magx = MAG_W'((px_reg + (PROD_W'(1) << 35)) >> 36);
    assign magy = MAG_W'((py_reg + (PROD_W'(1) << 35)) >> 36);

    always_comb
    begin
        sumx = (COORD_W+4)'(m2_reg.x);
        sumy = (COORD_W+4)'(m2_reg.y);
        if (m2_reg.vneg ^ m2_reg.dxneg)
            sumx = sumx - $signed((COORD_W+4)'(magx));
        else
            sumx = sumx + $signed((COORD_W+4)'(magx));
        if (m2_reg.vneg ^ m2_reg.dyneg)
            sumy = sumy - $signed((COORD_W+4)'(magy));
        else
            sumy = sumy + $signed((COORD_W+4)'(magy));
        if (sumx > CMAX)
            sumx = CMAX;
        else if (sumx < CMIN)
            sumx = CMIN;
        if (sumy > CMAX)
            sumy = CMAX;
        else if (sumy < CMIN)
            sumy = CMIN;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k3_reg   <= m2_reg.keep;
            c3_reg   <= m2_reg.keep && m2_reg.shift;
            i3_reg   <= m2_reg.keep ? m2_reg.intensity : '0;
            vel3_reg <= m2_reg.keep ? m2_reg.velocity : '0;
            z3_reg   <= m2_reg.keep ? m2_reg.z : '0;
            t3_reg   <= m2_reg.keep ? TOFF_W'(-$signed({1'b0, m2_reg.age})) : '0;
            if (!m2_reg.keep)
            begin
                x3_reg <= '0;
                y3_reg <= '0;
            end
            else if (m2_reg.shift)
            begin
                x3_reg <= sumx[COORD_W-1:0];
                y3_reg <= sumy[COORD_W-1:0];
            end
            else
            begin
                x3_reg <= m2_reg.x;
                y3_reg <= m2_reg.y;
            end
        end
    end

    assign out_valid     = v3_reg;
    assign keep          = k3_reg;
    assign compensated   = c3_reg;
    assign out_x         = x3_reg;
    assign out_y         = y3_reg;
    assign out_z         = z3_reg;
    assign out_intensity = i3_reg;
    assign out_velocity  = vel3_reg;
    assign out_toff      = t3_reg;

endmodule

// ===== verif/tb_top.sv =====
// self-checking testbench for radar_point_doppler_compensate: stream driver, result monitor,
// bit-exact doppler shift predictor; depends on rpdc_pkg and the rtl of the block
`timescale 1ns / 100ps

module tb_top;
    import rpdc_pkg::*;

    localparam int LATENCY  = 70;
    localparam int WD_LIMIT = 3000;

    typedef struct {
        logic                      keep;
        logic                      comp;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [15:0]               inten;
        logic signed [15:0]        vel;
        logic [TOFF_W-1:0]         toff;
    } shifted_pt_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [1:0]            m_axis_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [IDX_W-1:0]      cfg_index;
    logic [15:0]           cfg_data;

    // shadow of the register file
    logic [15:0] thr_inten;
    logic        flag_project;
    logic        flag_doppler;
    logic [15:0] thr_range;

    point_t      point_q[$];
    shifted_pt_t shifted_q[$];
    point_t      cur_point;
    int          accepted_in;
    int          seen_in;
    int          hold_left;
    logic        hold_done;
    int          idle_cnt;
    int          err_cnt;

    radar_point_doppler_compensate uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > n)
            bt = bt >> 2;
        while (bt != 0)
        begin
            if (n >= res + bt)
            begin
                n = n - (res + bt);
                res = (res >> 1) + bt;
            end
            else
                res = res >> 1;
            bt = bt >> 2;
        end
        return res;
    endfunction

    // signed radial step of one axis, rounded half away from zero
    function automatic longint radial_step(longint d, longint unsigned r7,
                                           longint unsigned vmag, logic vneg,
                                           longint unsigned age);
        longint unsigned dmag;
        longint unsigned unit;
        longint unsigned mag;
        dmag = (d < 0) ? -d : d;
        unit = ((dmag << 31) + (r7 >> 1)) / r7;
        if (unit > (64'd1 << 24))
            unit = 64'd1 << 24;
        mag = (vmag * age * unit + (64'd1 << 35)) >> 36;
        return (vneg != (d < 0)) ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic longint clamp24(longint v);
        if (v > 64'sd8388607)
            return 64'sd8388607;
        if (v < -64'sd8388608)
            return -64'sd8388608;
        return v;
    endfunction

    function automatic shifted_pt_t compensate_point(point_t p);
        shifted_pt_t r;
        longint x;
        longint y;
        longint dx;
        longint dy;
        longint unsigned sq;
        longint unsigned r7;
        longint unsigned vmag;
        r = '{default: '0};
        if (p.intensity < thr_inten)
            return r;
        x = p.point_x;
        y = p.point_y;
        r.keep = 1'b1;
        if (flag_doppler && p.frame_age != 0 && p.velocity_valid)
        begin
            dx = x - longint'(p.origin_x);
            dy = y - longint'(p.origin_y);
            sq = dx * dx + dy * dy;
            if (sq > longint'(thr_range) * longint'(thr_range))
            begin
                r7 = int_sqrt(sq << 14);
                vmag = (p.radial_velocity < 0) ? -longint'(p.radial_velocity)
                                               : longint'(p.radial_velocity);
                x = clamp24(x + radial_step(dx, r7, vmag, p.radial_velocity < 0,
                                            p.frame_age));
                y = clamp24(y + radial_step(dy, r7, vmag, p.radial_velocity < 0,
                                            p.frame_age));
                r.comp = 1'b1;
            end
        end
        r.x = x[23:0];
        r.y = y[23:0];
        r.z = flag_project ? '0 : p.point_z;
        r.inten = p.intensity;
        r.vel = p.radial_velocity;
        r.toff = 21'd0 - {1'b0, p.frame_age};
        return r;
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_point(point_t p);
        return {4'd0, p.origin_y, p.origin_x, p.frame_age,
                p.radial_velocity, p.intensity, p.point_z, p.point_y, p.point_x};
    endfunction

    function automatic logic signed [23:0] rand_coord();
        logic signed [23:0] c;
        c = 24'($urandom);
        return c >>> $urandom_range(0, 22);
    endfunction

    function automatic point_t rand_point();
        point_t p;
        p.point_x = 24'($urandom);
        p.point_y = 24'($urandom);
        p.point_z = 24'($urandom);
        p.intensity = 16'($urandom);
        p.radial_velocity = 16'($urandom);
        p.velocity_valid = 1'($urandom);
        p.frame_age = 20'($urandom);
        p.origin_x = 24'($urandom);
        p.origin_y = 24'($urandom);
        // most points are shiftable candidates with varied magnitudes
        if ($urandom_range(0, 9) >= 3)
        begin
            p.point_x = rand_coord();
            p.point_y = rand_coord();
            p.origin_x = rand_coord();
            p.origin_y = rand_coord();
            p.intensity = 16'($urandom_range(thr_inten, 65535));
            p.velocity_valid = ($urandom_range(0, 19) != 0);
            p.frame_age = ($urandom_range(0, 3) == 0) ? 20'($urandom_range(0, 4))
                                                      : 20'($urandom);
            p.radial_velocity = $signed(16'($urandom)) >>> $urandom_range(0, 8);
        end
        return p;
    endfunction

    function automatic point_t make_point(int x, int y, int ox, int oy, int inten,
                                          int vel, int age, bit vv);
        point_t p;
        p.point_x = 24'(x);
        p.point_y = 24'(y);
        p.point_z = 24'($urandom);
        p.intensity = 16'(inten);
        p.radial_velocity = 16'(vel);
        p.velocity_valid = vv;
        p.frame_age = 20'(age);
        p.origin_x = 24'(ox);
        p.origin_y = 24'(oy);
        return p;
    endfunction

    task automatic add_point(point_t p);
        point_q.insert(point_q.size(), p);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_INTENSITY_MIN:    thr_inten = val;
            REG_PROJECT_TO_PLANE: flag_project = val[0];
            REG_DOPPLER_ENABLE:   flag_doppler = val[0];
            REG_MIN_PLANAR_RANGE: thr_range = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (point_q.size() != 0 || s_axis_tvalid || shifted_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic queue_random(int n);
        repeat (n) add_point(rand_point());
    endtask

    // input side: next item once the current one is taken
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || accepted_in != seen_in))
        begin
            seen_in = accepted_in;
            if (point_q.size() != 0 &&
                ((accepted_in >= 500 && accepted_in < 700) || $urandom_range(0, 99) >= 22))
            begin
                cur_point = point_q[0];
                point_q.delete(0);
                s_axis_tdata <= pack_point(cur_point);
                s_axis_tuser <= cur_point.velocity_valid;
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // output side, with one long hold-off to fill the pipeline
    always @(negedge clk)
    begin
        if (!hold_done && accepted_in == 30)
        begin
            hold_done = 1'b1;
            hold_left = 400;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= (accepted_in >= 500 && accepted_in < 700) ||
                             $urandom_range(0, 99) >= 22;
    end

    task automatic report(string fld, longint e, longint a);
        err_cnt = err_cnt + 1;
        if (err_cnt <= 10)
            $display("mismatch %s: expected %0d got %0d", fld, e, a);
    endtask

    always @(posedge clk)
    begin
        shifted_pt_t e;
        shifted_pt_t a;
        logic        act;
        act = 1'b0;
        if (s_axis_tvalid && s_axis_tready)
        begin
            shifted_q.insert(shifted_q.size(), compensate_point(cur_point));
            accepted_in <= accepted_in + 1;
            act = 1'b1;
        end
        if (cfg_valid && cfg_ready)
            act = 1'b1;
        if (m_axis_tvalid && m_axis_tready)
        begin
            act = 1'b1;
            a.x = m_axis_tdata[23:0];
            a.y = m_axis_tdata[47:24];
            a.z = m_axis_tdata[71:48];
            a.inten = m_axis_tdata[87:72];
            a.vel = m_axis_tdata[103:88];
            a.toff = m_axis_tdata[124:104];
            a.keep = m_axis_tuser[0];
            a.comp = m_axis_tuser[1];
            if (shifted_q.size() == 0)
                report("unexpected item", 0, 1);
            else
            begin
                e = shifted_q[0];
                shifted_q.delete(0);
                if (a.keep !== e.keep)   report("keep", e.keep, a.keep);
                if (a.comp !== e.comp)   report("compensated", e.comp, a.comp);
                if (a.x !== e.x)         report("out_x", e.x, a.x);
                if (a.y !== e.y)         report("out_y", e.y, a.y);
                if (a.z !== e.z)         report("out_z", e.z, a.z);
                if (a.inten !== e.inten) report("out_intensity", e.inten, a.inten);
                if (a.vel !== e.vel)     report("out_velocity", e.vel, a.vel);
                if (a.toff !== e.toff)   report("out_toff", $signed(e.toff),
                                                $signed(a.toff));
            end
        end
        idle_cnt <= act ? 0 : idle_cnt + 1;
        if (idle_cnt >= WD_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_INTENSITY_MIN;
        cfg_data = '0;
        thr_inten = 16'd240;
        flag_project = 1'b1;
        flag_doppler = 1'b1;
        thr_range = 16'd4;
        accepted_in = 0;
        seen_in = 0;
        hold_left = 0;
        hold_done = 1'b0;
        idle_cnt = 0;
        err_cnt = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: threshold edges, zero age, invalid velocity, range edge
        add_point(make_point(1000, 2000, 0, 0, 239, 100, 500, 1));
        add_point(make_point(1000, 2000, 0, 0, 240, 100, 500, 1));
        add_point(make_point(1000, 2000, 0, 0, 65535, 100, 0, 1));
        add_point(make_point(1000, 2000, 0, 0, 65535, 100, 500, 0));
        add_point(make_point(4, 0, 0, 0, 500, 1000, 5000, 1));
        add_point(make_point(5, 0, 0, 0, 500, 1000, 5000, 1));
        add_point(make_point(3, 3, 0, 0, 500, -1000, 5000, 1));
        add_point(make_point(8388607, 8388607, -8388608, -8388608, 65535,
                             32767, 1048575, 1));
        add_point(make_point(-8388608, -8388608, 8388607, 8388607, 65535,
                             32767, 1048575, 1));
        add_point(make_point(-8388608, 8388607, 0, 0, 65535, -32768, 1048575, 1));
        add_point(make_point(8388607, -8388608, 0, 0, 65535, -32768, 1048575, 1));
        add_point(make_point(0, 0, 0, 0, 300, 500, 500, 1));
        add_point(make_point(-40960, 0, 0, 0, 300, 256, 65536, 1));
        add_point(make_point(0, -40960, 0, 0, 300, -256, 65536, 1));
        add_point(make_point(12345, -6789, 100, -200, 300, 1, 1, 1));
        add_point(make_point(8388000, 0, 0, 0, 300, 32767, 1048575, 1));
        add_point(make_point(1000, 1000, 1000, 1005, 0, 100, 100, 1));
        add_point(make_point(1000, 1000, 1000, 1005, 240, 0, 100, 1));
        queue_random(180);
        drain();

        write_reg(REG_INTENSITY_MIN, 16'd0);
        write_reg(REG_PROJECT_TO_PLANE, 16'd0);
        write_reg(REG_DOPPLER_ENABLE, 16'd1);
        write_reg(REG_MIN_PLANAR_RANGE, 16'd0);
        add_point(make_point(0, 0, 0, 0, 0, 100, 100, 1));
        add_point(make_point(1, 0, 0, 0, 0, 100, 100, 1));
        queue_random(240);
        drain();

        write_reg(REG_INTENSITY_MIN, 16'hFFFF);
        write_reg(REG_PROJECT_TO_PLANE, 16'd1);
        write_reg(REG_DOPPLER_ENABLE, 16'd0);
        write_reg(REG_MIN_PLANAR_RANGE, 16'hFFFF);
        // unknown index must leave every register alone
        write_reg(reg_idx_t'(8'hFF), 16'd7);
        queue_random(150);
        drain();

        write_reg(REG_INTENSITY_MIN, 16'd1000);
        write_reg(REG_PROJECT_TO_PLANE, 16'd0);
        write_reg(REG_DOPPLER_ENABLE, 16'd1);
        write_reg(REG_MIN_PLANAR_RANGE, 16'hFFFF);
        add_point(make_point(65535, 0, 0, 0, 2000, 100, 100, 1));
        add_point(make_point(65536, 0, 0, 0, 2000, 100, 100, 1));
        queue_random(260);
        drain();

        write_reg(REG_INTENSITY_MIN, 16'($urandom_range(0, 4000)));
        write_reg(REG_PROJECT_TO_PLANE, 16'($urandom_range(0, 1)));
        write_reg(REG_DOPPLER_ENABLE, 16'd1);
        write_reg(REG_MIN_PLANAR_RANGE, 16'($urandom));
        queue_random(300);
        drain();

        if (err_cnt == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/rpdc_pkg.sv
rtl/rpdc_front.sv
rtl/rpdc_isqrt.sv
rtl/rpdc_div.sv
rtl/rpdc_back.sv
rtl/radar_point_doppler_compensate.sv
verif/tb_top.sv
